### rtl/ets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_pkg: shared types and constants of the event task scheduler
// Table size, field widths, opcodes, status codes and controller commands.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int MaxTasks = 16;
  localparam int IdxW     = $clog2(MaxTasks);
  localparam int CntW     = $clog2(MaxTasks + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_DELETE  = 3'd1;
  localparam logic [2:0] OP_MOVE    = 3'd2;
  localparam logic [2:0] OP_TRIGGER = 3'd3;
  localparam logic [2:0] OP_SUSPEND = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Scan kinds used by the datapath's sequential search.
  typedef enum logic [2:0] {
    SCAN_FREE,      // first unused entry
    SCAN_WAIT_ID,   // newest waiting entry with matching id
    SCAN_READY_ID,  // first ready entry in ready order with matching id
    SCAN_READY_ANY, // head of the ready order
    SCAN_PENDING    // newest entry among the trigger pending set
  } scan_kind_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ADD,
    ACT_DELETE,
    ACT_TO_WAIT,
    ACT_WAKE
  } act_t;

  typedef struct packed {
    logic       latch;      // capture command fields
    logic       scan_start; // restart the scan pointer
    scan_kind_t kind;
    logic       load_pend;  // build the trigger pending set
    act_t       act;        // update applied to the found entry
    logic       clr_woken;
    logic       head_start; // start the closing head scan and counts
  } ets_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic pend_any;
  } ets_stat_t;

endpackage

### rtl/ets_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_datapath: task table and sequential search unit
// Holds the entries and the age matrix, and walks the table one entry a cycle.
// ----------------------------------------------------------------------------
module ets_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_task_ident,
  input  logic [7:0]        in_task_prio,
  input  logic [7:0]        in_event_ident,
  input  ets_pkg::ets_cmd_t cmd,
  output ets_pkg::ets_stat_t stat,
  output logic              running_valid,
  output logic [7:0]        running_task,
  output ets_pkg::cnt_t     ready_count,
  output ets_pkg::cnt_t     waiting_count,
  output ets_pkg::cnt_t     woken_count
);
  import ets_pkg::*;

  logic [MaxTasks-1:0] used_r, waiting_r, pend_r;
  logic [MaxTasks-1:0] age_r [MaxTasks];
  logic [7:0] task_r [MaxTasks];
  logic [7:0] prio_r [MaxTasks];
  logic [7:0] event_r [MaxTasks];

  logic [7:0] id_r, pr_r, ev_r;
  scan_kind_t kind_r;
  logic [CntW-1:0] ptr_r;
  logic busy_r, found_r;
  idx_t best_r;
  cnt_t nrdy_r, nwait_r, woken_r;

  idx_t cur;
  logic cand, better, rdy_cur;
  logic [MaxTasks-1:0] pend_nxt;

  assign cur     = ptr_r[IdxW-1:0];
  assign rdy_cur = used_r[cur] && !waiting_r[cur];

  always_comb begin
    cand = 1'b0;
    case (kind_r)
      SCAN_FREE:      cand = !used_r[cur];
      SCAN_WAIT_ID:   cand = used_r[cur] && waiting_r[cur] && task_r[cur] == id_r;
      SCAN_READY_ID:  cand = rdy_cur && task_r[cur] == id_r;
      SCAN_READY_ANY: cand = rdy_cur;
      SCAN_PENDING:   cand = pend_r[cur];
      default:        cand = 1'b0;
    endcase
  end

  always_comb begin
    better = 1'b0;
    case (kind_r)
      SCAN_FREE:    better = 1'b0;
      SCAN_WAIT_ID, SCAN_PENDING: better = age_r[cur][best_r];
      default: begin
        if (prio_r[cur] != prio_r[best_r]) better = prio_r[cur] < prio_r[best_r];
        else better = age_r[best_r][cur];
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MaxTasks; i++)
      pend_nxt[i] = used_r[i] && waiting_r[i] && event_r[i] == ev_r;
  end

  assign stat.scan_done = busy_r == 1'b0;
  assign stat.found     = found_r;
  assign stat.pend_any  = |pend_r;

  assign running_valid = found_r;
  assign running_task  = found_r ? task_r[best_r] : 8'd0;
  assign ready_count   = nrdy_r;
  assign waiting_count = nwait_r;
  assign woken_count   = woken_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      id_r <= in_task_ident;
      pr_r <= in_task_prio;
      ev_r <= in_event_ident;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      waiting_r <= '0;
      pend_r    <= '0;
      busy_r    <= 1'b0;
      found_r   <= 1'b0;
      ptr_r     <= '0;
      kind_r    <= SCAN_FREE;
      best_r    <= '0;
      nrdy_r    <= '0;
      nwait_r   <= '0;
      woken_r   <= '0;
      for (int i = 0; i < MaxTasks; i++) age_r[i] <= '0;
    end else begin
      if (cmd.clr_woken) woken_r <= '0;
      if (cmd.load_pend) pend_r <= pend_nxt;
      if (cmd.scan_start || cmd.head_start) begin
        busy_r  <= 1'b1;
        found_r <= 1'b0;
        ptr_r   <= '0;
        best_r  <= '0;
        kind_r  <= cmd.head_start ? SCAN_READY_ANY : cmd.kind;
        if (cmd.head_start) begin
          nrdy_r  <= '0;
          nwait_r <= '0;
        end
      end else if (busy_r) begin
        if (cand && (!found_r || better)) begin
          found_r <= 1'b1;
          best_r  <= cur;
        end
        if (kind_r == SCAN_READY_ANY) begin
          if (rdy_cur) nrdy_r <= nrdy_r + cnt_t'(1);
          if (used_r[cur] && waiting_r[cur]) nwait_r <= nwait_r + cnt_t'(1);
        end
        // The free slot search stops at the first hit.
        if (ptr_r == CntW'(MaxTasks - 1) || (kind_r == SCAN_FREE && cand))
          busy_r <= 1'b0;
        ptr_r <= ptr_r + CntW'(1);
      end
      case (cmd.act)
        ACT_ADD: begin
          used_r[best_r]    <= 1'b1;
          waiting_r[best_r] <= ev_r != 8'd0;
        end
        ACT_DELETE: begin
          used_r[best_r]    <= 1'b0;
          waiting_r[best_r] <= 1'b0;
        end
        ACT_TO_WAIT: waiting_r[best_r] <= 1'b1;
        ACT_WAKE: begin
          waiting_r[best_r] <= 1'b0;
          pend_r[best_r]    <= 1'b0;
          woken_r           <= woken_r + cnt_t'(1);
        end
        default: ;
      endcase
      // A deleted entry drops out of the age order; any other update makes
      // the entry the newest of all.
      if (cmd.act != ACT_NONE) begin
        for (int k = 0; k < MaxTasks; k++) begin
          if (k == int'(best_r))
            age_r[k] <= (cmd.act == ACT_DELETE) ? '0 : ~(MaxTasks'(1) << best_r);
          else
            age_r[k] <= age_r[k] & ~(MaxTasks'(1) << best_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_ADD) begin
      task_r[best_r]  <= id_r;
      prio_r[best_r]  <= pr_r;
      event_r[best_r] <= ev_r;
    end else if (cmd.act == ACT_TO_WAIT) begin
      event_r[best_r] <= ev_r;
    end
  end

endmodule

### rtl/ets_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_controller: command sequencer of the event task scheduler
// Orders the scans and table updates for each opcode and issues the result.
// ----------------------------------------------------------------------------
module ets_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         in_opcode,
  input  ets_pkg::ets_stat_t stat,
  output ets_pkg::ets_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid,
  output logic [1:0]         out_status
);
  import ets_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN1, S_SCAN2, S_TRIG, S_HEAD, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [1:0] status_r, status_nxt;
  logic valid_r, valid_nxt;

  assign busy       = state_r != S_IDLE;
  assign out_valid  = valid_r;
  assign out_status = status_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    valid_nxt  = 1'b0;
    cmd        = '0;
    cmd.kind   = SCAN_FREE;
    cmd.act    = ACT_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch     = 1'b1;
          cmd.clr_woken = 1'b1;
          op_nxt        = in_opcode;
          status_nxt    = ST_OK;
          cmd.scan_start = 1'b1;
          state_nxt     = S_SCAN1;
          case (in_opcode)
            OP_ADD:     cmd.kind = SCAN_FREE;
            OP_DELETE:  cmd.kind = SCAN_WAIT_ID;
            OP_MOVE:    cmd.kind = SCAN_READY_ID;
            OP_SUSPEND: cmd.kind = SCAN_READY_ANY;
            OP_TRIGGER: begin
              cmd.scan_start = 1'b0;
              state_nxt      = S_TRIG;
            end
            default: begin
              cmd.scan_start = 1'b0;
              cmd.head_start = 1'b1;
              state_nxt      = S_HEAD;
            end
          endcase
        end
      end
      S_SCAN1: begin
        if (stat.scan_done) begin
          if (stat.found) begin
            case (op_r)
              OP_ADD:    cmd.act = ACT_ADD;
              OP_DELETE: cmd.act = ACT_DELETE;
              default:   cmd.act = ACT_TO_WAIT;
            endcase
            cmd.head_start = 1'b1;
            state_nxt = S_HEAD;
          end else if (op_r == OP_DELETE) begin
            cmd.scan_start = 1'b1;
            cmd.kind       = SCAN_READY_ID;
            state_nxt      = S_SCAN2;
          end else begin
            case (op_r)
              OP_ADD:  status_nxt = ST_FULL;
              OP_MOVE: status_nxt = ST_NOT_FOUND;
              default: status_nxt = ST_EMPTY;
            endcase
            cmd.head_start = 1'b1;
            state_nxt = S_HEAD;
          end
        end
      end
      S_SCAN2: begin
        if (stat.scan_done) begin
          if (stat.found) cmd.act = ACT_DELETE;
          else status_nxt = ST_NOT_FOUND;
          cmd.head_start = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_TRIG: begin
        // Load the pending set and start the search for its newest entry.
        cmd.load_pend = 1'b1;
        state_nxt     = S_SCAN2;
        cmd.scan_start = 1'b1;
        cmd.kind       = SCAN_PENDING;
      end
      S_HEAD: begin
        if (stat.scan_done) begin
          valid_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // Trigger walk: after the pending scan, wake the newest and rescan.
    if (op_r == OP_TRIGGER && state_r == S_SCAN2) begin
      cmd.scan_start = 1'b0;
      cmd.head_start = 1'b0;
      cmd.act        = ACT_NONE;
      status_nxt     = ST_OK;
      state_nxt      = S_SCAN2;
      if (stat.scan_done) begin
        if (stat.found && stat.pend_any) begin
          cmd.act        = ACT_WAKE;
          cmd.scan_start = 1'b1;
          cmd.kind       = SCAN_PENDING;
        end else begin
          cmd.head_start = 1'b1;
          state_nxt      = S_HEAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      op_r     <= '0;
      status_r <= ST_OK;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      status_r <= status_nxt;
      valid_r  <= valid_nxt;
    end
  end

endmodule

### rtl/event_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_task_scheduler: priority ready queue with event wait
// Command-driven task table with a sequential scan controller.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_opcode, in_task_ident, in_task_prio and in_event_ident and pulse
//   start while busy is low; the command is taken at that clock edge.
//   The result appears on the out_ ports for one cycle, marked by out_valid;
//   it reports the status and the ready head, set counts and woken count
//   after the command. busy falls in the cycle after the result cycle.
//   The single search unit reads one entry a cycle, and every command ends
//   with a scan for the ready head and counts. The free slot search of add
//   stops at the first unused entry; delete searches the waiting entries
//   first and the ready entries only when no waiting entry matches; trigger
//   rescans the pending set after each woken task; unused opcodes run only
//   the head scan.
//   Reset empties the table; no clearing pass is needed.
//   The receiver cannot stall; results must be taken when shown.
// ----------------------------------------------------------------------------
module event_task_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_opcode,
  input  logic [7:0]          in_task_ident,
  input  logic [7:0]          in_task_prio,
  input  logic [7:0]          in_event_ident,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic                out_running_valid,
  output logic [7:0]          out_running_task,
  output logic [4:0]          out_ready_count,
  output logic [4:0]          out_waiting_count,
  output logic [4:0]          out_woken_count
);
  import ets_pkg::*;

  ets_cmd_t  cmd;
  ets_stat_t stat;
  cnt_t nrdy, nwait, nwoken;

  ets_controller u_ctrl (
    .clk, .rst_n, .start, .in_opcode, .stat, .cmd, .busy,
    .out_valid, .out_status
  );

  ets_datapath u_dp (
    .clk, .rst_n, .in_task_ident, .in_task_prio, .in_event_ident,
    .cmd, .stat,
    .running_valid (out_running_valid),
    .running_task  (out_running_task),
    .ready_count   (nrdy),
    .waiting_count (nwait),
    .woken_count   (nwoken)
  );

  assign out_ready_count   = 5'(nrdy);
  assign out_waiting_count = 5'(nwait);
  assign out_woken_count   = 5'(nwoken);

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for event_task_scheduler
// Commands are queued by an initial block and driven by a clocked driver.
// A behavioral model of the task table predicts each result, and a clocked
// monitor compares every transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ets_pkg::*;

  localparam int NT = MaxTasks;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] task_ident;
    logic [7:0] task_prio;
    logic [7:0] event_ident;
  } sched_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       running_valid;
    logic [7:0] running_task;
    logic [4:0] ready_count;
    logic [4:0] waiting_count;
    logic [4:0] woken_count;
  } sched_view_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_opcode = '0;
  logic [7:0] in_task_ident = '0;
  logic [7:0] in_task_prio = '0;
  logic [7:0] in_event_ident = '0;
  logic       out_valid;
  logic [1:0] out_status;
  logic       out_running_valid;
  logic [7:0] out_running_task;
  logic [4:0] out_ready_count;
  logic [4:0] out_waiting_count;
  logic [4:0] out_woken_count;

  event_task_scheduler DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_task_ident(in_task_ident),
    .in_task_prio(in_task_prio), .in_event_ident(in_event_ident),
    .out_valid(out_valid), .out_status(out_status),
    .out_running_valid(out_running_valid), .out_running_task(out_running_task),
    .out_ready_count(out_ready_count), .out_waiting_count(out_waiting_count),
    .out_woken_count(out_woken_count)
  );

  always #10 clk = ~clk;

  // Shadow copy of the task table.
  logic          tbl_used [NT];
  logic          tbl_wait [NT];
  logic [7:0]    tbl_id   [NT];
  logic [7:0]    tbl_prio [NT];
  logic [7:0]    tbl_ev   [NT];
  logic [NT-1:0] tbl_age  [NT];

  sched_cmd_t  cmd_queue[$];
  sched_view_t expected_views[$];
  int          idle_pct = 10;
  bit          hold_for_drain = 1'b0;
  bit          stim_done = 1'b0;
  int          mismatches = 0;
  int          watchdog = 0;

  function automatic bit newer(int a, int b);
    return tbl_age[a][b];
  endfunction

  function automatic void promote_newest(int i);
    for (int k = 0; k < NT; k++) begin
      tbl_age[k][i] = 1'b0;
      if (k != i) tbl_age[i][k] = 1'b1;
    end
  endfunction

  function automatic bit runs_before(int a, int b);
    if (tbl_prio[a] != tbl_prio[b]) return tbl_prio[a] < tbl_prio[b];
    return newer(b, a);
  endfunction

  function automatic int pick_ready(bit match_id, logic [7:0] id);
    int best;
    best = -1;
    for (int i = 0; i < NT; i++) begin
      if (!tbl_used[i] || tbl_wait[i] || (match_id && tbl_id[i] != id)) continue;
      if (best < 0 || runs_before(i, best)) best = i;
    end
    return best;
  endfunction

  function automatic sched_view_t schedule(sched_cmd_t c);
    sched_view_t v;
    int sel, head;
    logic [NT-1:0] pend;
    v = '0;
    sel = -1;
    case (c.opcode)
      OP_ADD: begin
        for (int i = 0; i < NT && sel < 0; i++) if (!tbl_used[i]) sel = i;
        if (sel < 0) v.status = ST_FULL;
        else begin
          tbl_used[sel] = 1'b1;
          tbl_wait[sel] = (c.event_ident != 0);
          tbl_id[sel] = c.task_ident;
          tbl_prio[sel] = c.task_prio;
          tbl_ev[sel] = c.event_ident;
          promote_newest(sel);
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < NT; i++)
          if (tbl_used[i] && tbl_wait[i] && tbl_id[i] == c.task_ident &&
              (sel < 0 || newer(i, sel))) sel = i;
        if (sel < 0) sel = pick_ready(1'b1, c.task_ident);
        if (sel < 0) v.status = ST_NOT_FOUND;
        else begin
          tbl_used[sel] = 1'b0;
          tbl_wait[sel] = 1'b0;
          tbl_age[sel] = '0;
          for (int i = 0; i < NT; i++) tbl_age[i][sel] = 1'b0;
        end
      end
      OP_MOVE, OP_SUSPEND: begin
        sel = pick_ready(c.opcode == OP_MOVE, c.task_ident);
        if (sel < 0) v.status = (c.opcode == OP_MOVE) ? ST_NOT_FOUND : ST_EMPTY;
        else begin
          tbl_wait[sel] = 1'b1;
          tbl_ev[sel] = c.event_ident;
          promote_newest(sel);
        end
      end
      OP_TRIGGER: begin
        pend = '0;
        for (int i = 0; i < NT; i++)
          if (tbl_used[i] && tbl_wait[i] && tbl_ev[i] == c.event_ident) pend[i] = 1'b1;
        while (pend != 0) begin
          sel = -1;
          for (int i = 0; i < NT; i++)
            if (pend[i] && (sel < 0 || newer(i, sel))) sel = i;
          pend[sel] = 1'b0;
          tbl_wait[sel] = 1'b0;
          promote_newest(sel);
          v.woken_count++;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NT; i++)
      if (tbl_used[i]) begin
        if (tbl_wait[i]) v.waiting_count++;
        else v.ready_count++;
      end
    head = pick_ready(1'b0, 8'd0);
    v.running_valid = (head >= 0);
    v.running_task = (head >= 0) ? tbl_id[head] : 8'd0;
    return v;
  endfunction

  // Ids come from a small pool most of the time so that commands hit.
  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) c.opcode = OP_ADD;
    else if (r < 55) c.opcode = OP_DELETE;
    else if (r < 70) c.opcode = OP_MOVE;
    else if (r < 85) c.opcode = OP_TRIGGER;
    else if (r < 96) c.opcode = OP_SUSPEND;
    else c.opcode = 3'($urandom_range(5, 7));
    c.task_ident = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    c.task_prio = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    if ($urandom_range(0, 2) == 0) c.event_ident = 8'd0;
    else if ($urandom_range(0, 4) != 0) c.event_ident = 8'($urandom_range(1, 3));
    else c.event_ident = 8'($urandom);
    return c;
  endfunction

  function automatic sched_cmd_t mk(logic [2:0] op, logic [7:0] id, logic [7:0] pr,
                                    logic [7:0] ev);
    sched_cmd_t c;
    c.opcode = op; c.task_ident = id; c.task_prio = pr; c.event_ident = ev;
    return c;
  endfunction

  initial begin
    for (int i = 0; i < NT; i++) begin
      tbl_used[i] = 1'b0; tbl_wait[i] = 1'b0; tbl_id[i] = '0;
      tbl_prio[i] = '0; tbl_ev[i] = '0; tbl_age[i] = '0;
    end
    // Directed: empty-set cases, extremes, full table, wakes and unused opcodes.
    cmd_queue.push_back(mk(OP_SUSPEND, 8'd0, 8'd0, 8'd5));
    cmd_queue.push_back(mk(OP_DELETE, 8'd9, 8'd0, 8'd0));
    cmd_queue.push_back(mk(OP_MOVE, 8'd9, 8'd0, 8'd1));
    cmd_queue.push_back(mk(OP_TRIGGER, 8'd0, 8'd0, 8'd7));
    for (int i = 0; i < 17; i++)
      cmd_queue.push_back(mk(OP_ADD, (i == 0) ? 8'hFF : 8'(i), (i % 2) ? 8'hFF : 8'h00,
                             (i % 3 == 0) ? 8'hFF : 8'h00));
    cmd_queue.push_back(mk(OP_TRIGGER, 8'hAA, 8'h55, 8'hFF));
    cmd_queue.push_back(mk(OP_MOVE, 8'd2, 8'h00, 8'h00));
    cmd_queue.push_back(mk(OP_DELETE, 8'hFF, 8'hFF, 8'hFF));
    cmd_queue.push_back(mk(3'd7, 8'h55, 8'hAA, 8'h55));
    for (int n = 0; n < 1575; n++) cmd_queue.push_back(rand_cmd());
  end

  // Driver: one command at a time, with random idle cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      start <= 1'b0;
    end else if (!start && !busy && cmd_queue.size() > 0 && !hold_for_drain) begin
      if ($urandom_range(0, 99) >= idle_pct) begin
        sched_cmd_t c;
        c = cmd_queue.pop_front();
        in_opcode <= c.opcode;
        in_task_ident <= c.task_ident;
        in_task_prio <= c.task_prio;
        in_event_ident <= c.event_ident;
        start <= 1'b1;
        expected_views.push_back(schedule(c));
        if (cmd_queue.size() == 1100) hold_for_drain <= 1'b1;
        if (cmd_queue.size() == 800) idle_pct <= 48;
        if (cmd_queue.size() == 400) idle_pct <= 0;
      end
    end else if (hold_for_drain && expected_views.size() == 0) begin
      hold_for_drain <= 1'b0;
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid || (start && !busy)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (out_valid) begin
        sched_view_t got, exp_v;
        got = {out_status, out_running_valid, out_running_task, out_ready_count,
               out_waiting_count, out_woken_count};
        if (expected_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected transaction: %p", got);
        end else begin
          exp_v = expected_views.pop_front();
          if (got !== exp_v) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_v, got);
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        wait (cmd_queue.size() == 0 && expected_views.size() == 0 && !start);
        repeat (100) @(posedge clk);
      end
      begin
        wait (watchdog >= WATCHDOG_LIMIT);
        mismatches++;
      end
    join_any
    if (mismatches == 0 && expected_views.size() == 0)
      $display("event_task_scheduler verification clean");
    else
      $display("event_task_scheduler verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/ets_pkg.sv
rtl/ets_datapath.sv
rtl/ets_controller.sv
rtl/event_task_scheduler.sv
test/tb.sv
